[src/vtcc_pkg.sv]
// ----------------------------------------------------------------------------
// vtcc_pkg
// shared types and constant tables for the vietnamese text character cleaner
// ----------------------------------------------------------------------------
package vtcc_pkg;

    typedef logic [15:0] t_unit;

    localparam t_unit SPACE_UNIT = 16'd32;
    localparam t_unit CR_UNIT    = 16'd13;
    localparam t_unit ASCII_TOP  = 16'd126;

    localparam int VIET_COUNT  = 134;
    localparam int PUNCT_COUNT = 25;

    typedef struct packed {
        logic is_cr;
        logic is_sep;
        logic is_space;
    } t_cls;

    typedef struct packed {
        logic swallow_next;
        logic last_was_space;
    } t_flags;

    localparam t_unit VIET_LETTERS [0:VIET_COUNT-1] = '{
        16'd225,  16'd224,  16'd7843, 16'd227,  16'd7841, 16'd259,  16'd7855, 16'd7857,
        16'd7859, 16'd7861, 16'd7863, 16'd226,  16'd7845, 16'd7847, 16'd7849, 16'd7851,
        16'd7853, 16'd193,  16'd192,  16'd7842, 16'd195,  16'd7840, 16'd258,  16'd7854,
        16'd7856, 16'd7858, 16'd7860, 16'd7862, 16'd194,  16'd7844, 16'd7846, 16'd7848,
        16'd7850, 16'd7852,
        16'd233,  16'd232,  16'd7867, 16'd7869, 16'd7865, 16'd234,  16'd7871, 16'd7873,
        16'd7875, 16'd7877, 16'd7879, 16'd201,  16'd200,  16'd7866, 16'd7868, 16'd7864,
        16'd202,  16'd7870, 16'd7872, 16'd7874, 16'd7876, 16'd7878,
        16'd417,  16'd7899, 16'd7901, 16'd7903, 16'd7905, 16'd7907, 16'd211,  16'd210,
        16'd7886, 16'd213,  16'd7884, 16'd212,  16'd7888, 16'd7890, 16'd7892, 16'd7894,
        16'd7896, 16'd416,  16'd7898, 16'd7900, 16'd7902, 16'd7904, 16'd7906, 16'd243,
        16'd242,  16'd7887, 16'd245,  16'd7885, 16'd244,  16'd7889, 16'd7891, 16'd7893,
        16'd7895, 16'd7897,
        16'd237,  16'd236,  16'd7881, 16'd297,  16'd7883, 16'd205,  16'd204,  16'd7880,
        16'd296,  16'd7882,
        16'd250,  16'd249,  16'd7911, 16'd361,  16'd7909, 16'd432,  16'd7913, 16'd7915,
        16'd7917, 16'd7919, 16'd7921, 16'd218,  16'd217,  16'd7910, 16'd360,  16'd7908,
        16'd431,  16'd7912, 16'd7914, 16'd7916, 16'd7918, 16'd7920,
        16'd253,  16'd7923, 16'd7927, 16'd7929, 16'd7925, 16'd221,  16'd7922, 16'd7926,
        16'd7928, 16'd7924,
        16'd272,  16'd273
    };

    // ? . , : ( ) { } " ' ! ; - / + * _ [ ] = # @ $ & |
    localparam t_unit PUNCT_UNITS [0:PUNCT_COUNT-1] = '{
        16'd63,  16'd46,  16'd44,  16'd58,  16'd40,  16'd41,  16'd123, 16'd125,
        16'd34,  16'd39,  16'd33,  16'd59,  16'd45,  16'd47,  16'd43,  16'd42,
        16'd95,  16'd91,  16'd93,  16'd61,  16'd35,  16'd64,  16'd36,  16'd38,
        16'd124
    };

endpackage

[src/vtcc_classify.sv]
// ----------------------------------------------------------------------------
// vtcc_classify
// sorts one code unit into carriage return, separator or plain space
// ----------------------------------------------------------------------------
module vtcc_classify (
    input  vtcc_pkg::t_unit i_unit,
    output vtcc_pkg::t_cls  o_cls
);
    import vtcc_pkg::*;

    logic viet_hit;
    logic punct_hit;

    always_comb begin
        viet_hit = 1'b0;
        for (int k = 0; k < VIET_COUNT; k++) begin
            if (i_unit == VIET_LETTERS[k]) begin
                viet_hit = 1'b1;
            end
        end
    end

    always_comb begin
        punct_hit = 1'b0;
        for (int k = 0; k < PUNCT_COUNT; k++) begin
            if (i_unit == PUNCT_UNITS[k]) begin
                punct_hit = 1'b1;
            end
        end
    end

    always_comb begin
        o_cls.is_cr    = (i_unit == CR_UNIT);
        o_cls.is_sep   = o_cls.is_cr || ((i_unit > ASCII_TOP) ? !viet_hit : punct_hit);
        o_cls.is_space = (i_unit == SPACE_UNIT);
    end

endmodule

[src/vtcc_decide.sv]
// ----------------------------------------------------------------------------
// vtcc_decide
// holds the swallow and last-space flags and picks the unit to append
// ----------------------------------------------------------------------------
module vtcc_decide (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  vtcc_pkg::t_unit  i_unit,
    input  logic             i_eod,
    input  vtcc_pkg::t_cls   i_cls,
    output logic             o_emit,
    output vtcc_pkg::t_unit  o_unit,
    output vtcc_pkg::t_flags o_flags
);
    import vtcc_pkg::*;

    t_flags r_flags;
    t_flags n_flags;
    t_flags s_flags;

    always_comb begin
        s_flags = r_flags;
        o_emit  = 1'b0;
        o_unit  = '0;
        priority if (r_flags.swallow_next) begin
            s_flags.swallow_next = 1'b0;
        end else if (i_cls.is_sep || i_cls.is_space) begin
            s_flags.swallow_next = i_cls.is_cr;
            if (!r_flags.last_was_space) begin
                o_emit                 = 1'b1;
                o_unit                 = SPACE_UNIT;
                s_flags.last_was_space = 1'b1;
            end
        end else begin
            o_emit                 = 1'b1;
            o_unit                 = i_unit;
            s_flags.last_was_space = 1'b0;
        end
    end

    always_comb begin
        n_flags = r_flags;
        if (i_step) begin
            if (i_eod) begin
                n_flags.swallow_next   = 1'b0;
                n_flags.last_was_space = 1'b1;
            end else begin
                n_flags = s_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.swallow_next   <= 1'b0;
            r_flags.last_was_space <= 1'b1;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

[src/vietnamese_text_char_cleaner.sv]
// ----------------------------------------------------------------------------
// vietnamese_text_char_cleaner
// cleans a utf-16 text stream one code unit per beat
// ----------------------------------------------------------------------------
// Every input beat gives exactly one output beat, and a new beat is taken in
// every cycle while the output does not stall: the unit is registered,
// classified against the letter and punctuation tables, decided against the
// two state flags and registered again. Separators collapse to one space, the
// unit after a carriage return is dropped, and a beat with end-of-document set
// returns the flags to the start-of-document state once it has been handled.
module vietnamese_text_char_cleaner (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  vtcc_pkg::t_unit i_code_unit,
    input  logic            i_end_of_document,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_emit,
    output vtcc_pkg::t_unit o_out_unit,
    output logic            o_doc_end
);
    import vtcc_pkg::*;

    logic   r_s1_valid;
    t_unit  r_s1_unit;
    logic   r_s1_eod;
    logic   r_out_valid;
    logic   r_out_emit;
    t_unit  r_out_unit;
    logic   r_out_eod;

    logic   out_free;
    logic   s1_fire;
    logic   in_take;
    t_cls   cls;
    logic   dec_emit;
    t_unit  dec_unit;
    t_flags flags;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_fire  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    vtcc_classify u_classify (
        .i_unit (r_s1_unit),
        .o_cls  (cls)
    );

    vtcc_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_fire),
        .i_unit  (r_s1_unit),
        .i_eod   (r_s1_eod),
        .i_cls   (cls),
        .o_emit  (dec_emit),
        .o_unit  (dec_unit),
        .o_flags (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_unit <= i_code_unit;
            r_s1_eod  <= i_end_of_document;
        end
        if (s1_fire) begin
            r_out_emit <= dec_emit;
            r_out_unit <= dec_unit;
            r_out_eod  <= r_s1_eod;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_emit     = r_out_emit;
    assign o_out_unit = r_out_unit;
    assign o_doc_end  = r_out_eod;

    // end of document returns the flags to the start state
    a_eod_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_eod |=> !flags.swallow_next && flags.last_was_space)
        else $error("flags not restored after end of document");

    // a carriage return that is not itself swallowed arms the swallow flag
    a_cr_arms : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !r_s1_eod && cls.is_cr && !flags.swallow_next |=> flags.swallow_next)
        else $error("carriage return did not arm swallow");

    // a beat with nothing appended carries a zero unit
    a_quiet_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_emit |-> o_out_unit == '0)
        else $error("non-zero unit on a quiet beat");

    // no two spaces in a row while the document runs
    a_no_double_space : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && dec_emit && dec_unit == SPACE_UNIT |-> !flags.last_was_space)
        else $error("space appended after a space");

endmodule
